// File: rtl/device_table_wildcard_search_unit_macros.svh
// Assertion macros for the device table search unit.
// Each macro expects clk and rst_n in scope.
`ifndef DEVICE_TABLE_WILDCARD_SEARCH_UNIT_MACROS_SVH
`define DEVICE_TABLE_WILDCARD_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication.
`define DTWS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtws assertion failed");

// Next-cycle implication.
`define DTWS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtws assertion failed");

`endif

// File: rtl/dtws_pkg.sv
package dtws_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    // Width used to compare an entry number against the start index
    localparam int CMP_W = 9;

    localparam int IN_W  = 80;
    localparam int OUT_W = 72;

    // Operation codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_CLASS  = 2'd1;
    localparam logic [1:0] ACT_POS    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [7:0]  cls_code;
        logic [7:0]  subclass_code;
        logic [15:0] vendor_code;
        logic [15:0] device_code;
        logic [7:0]  bus_number;
        logic [4:0]  slot_number;
        logic [2:0]  fn_number;
    } rec_t;

    // Operation travelling down the chain, with the result gathered so far
    typedef struct packed {
        logic [1:0]        action;
        logic [5:0]        previous_index;
        logic [8:0]        cls_code;
        logic [8:0]        subclass_code;
        logic [8:0]        bus_number;
        logic [5:0]        slot_number;
        logic [3:0]        fn_number;
        logic [15:0]       vendor_code;
        logic [15:0]       device_code;
        logic              done;
        logic [IDX_W-1:0]  res_idx;
        rec_t              res_rec;
    } tok_t;

endpackage

// File: rtl/dtws_cell.sv
module dtws_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [dtws_pkg::IDX_W-1:0]    cell_idx,
    input  logic                          tok_in_valid,
    input  dtws_pkg::tok_t                tok_in,
    output logic                          tok_out_valid,
    output dtws_pkg::tok_t                tok_out
);

    logic            entry_valid_reg;
    dtws_pkg::rec_t  entry_rec_reg;
    logic            tok_valid_reg;
    dtws_pkg::tok_t  tok_reg;
    dtws_pkg::tok_t  tok_next;

    dtws_pkg::rec_t  new_rec;
    logic            in_range;
    logic            cls_hit;
    logic            sub_hit;
    logic            bus_hit;
    logic            slot_hit;
    logic            fn_hit;
    logic            live;
    logic            do_insert;
    logic            do_hit;

    // Record built from the insert fields, cut to their stored widths
    always_comb
    begin
        new_rec.cls_code      = tok_in.cls_code[7:0];
        new_rec.subclass_code = tok_in.subclass_code[7:0];
        new_rec.vendor_code   = tok_in.vendor_code;
        new_rec.device_code   = tok_in.device_code;
        new_rec.bus_number    = tok_in.bus_number[7:0];
        new_rec.slot_number   = tok_in.slot_number[4:0];
        new_rec.fn_number     = tok_in.fn_number[2:0];
    end

    // Search window: a negative start covers every entry
    assign in_range = tok_in.previous_index[5]
                   || (dtws_pkg::CMP_W'(cell_idx) >
                       dtws_pkg::CMP_W'(tok_in.previous_index[4:0]));

    // Field compares; all ones is the wildcard, other negatives never match
    assign cls_hit  = (tok_in.cls_code == 9'h1FF)
                   || (tok_in.cls_code == {1'b0, entry_rec_reg.cls_code});
    assign sub_hit  = (tok_in.subclass_code == 9'h1FF)
                   || (tok_in.subclass_code == {1'b0, entry_rec_reg.subclass_code});
    assign bus_hit  = (tok_in.bus_number == 9'h1FF)
                   || (tok_in.bus_number == {1'b0, entry_rec_reg.bus_number});
    assign slot_hit = (tok_in.slot_number == 6'h3F)
                   || (tok_in.slot_number == {1'b0, entry_rec_reg.slot_number});
    assign fn_hit   = (tok_in.fn_number == 4'hF)
                   || (tok_in.fn_number == {1'b0, entry_rec_reg.fn_number});

    assign live      = tok_in_valid && !tok_in.done;
    assign do_insert = live && (tok_in.action == dtws_pkg::ACT_INSERT) && !entry_valid_reg;
    assign do_hit    = live && entry_valid_reg && in_range
                    && (((tok_in.action == dtws_pkg::ACT_CLASS) && cls_hit && sub_hit)
                     || ((tok_in.action == dtws_pkg::ACT_POS) && bus_hit && slot_hit
                         && fn_hit));

    // Claim the operation at this entry
    always_comb
    begin
        tok_next = tok_in;
        if (do_insert || do_hit)
        begin
            tok_next.done    = 1'b1;
            tok_next.res_idx = cell_idx;
            tok_next.res_rec = do_insert ? new_rec : entry_rec_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            tok_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            tok_valid_reg <= tok_in_valid;
            if (do_insert)
            begin
                entry_valid_reg <= 1'b1;
            end
        end
    end

    // Payload: hand the transaction on and store an inserted record
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tok_reg <= tok_next;
            if (do_insert)
            begin
                entry_rec_reg <= new_rec;
            end
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

// File: rtl/device_table_wildcard_search_unit.sv
// Device table with wildcard first-match search.
// Input transactions arrive on s_tvalid/s_tready/s_tdata; each one is an
// insert, a find by class/subclass or a find by bus/slot/function. Every
// transaction gives exactly one result on m_tvalid/m_tready/m_tdata.
// The table is a chain of TABLE_ENTRIES cells, one entry per cell. An
// operation steps one cell per cycle unless the chain stalls; the first
// cell that can take it (a free entry for an insert, a valid matching
// entry past the start index for a search) records its answer and later
// cells pass it on unchanged. Operations keep their order through the chain,
// so each entry sees them in the order they were accepted.
// Each result passes through the 32 cells and then the output register.
// Throughput: one transaction per cycle while the output is taken; the
// chain length sets the latency, not the rate.
// Reset clears every entry's valid bit and empties the chain; no clearing
// pass is needed.
// When the receiver holds m_tready low with a result waiting, the whole
// chain and s_tready stall until that result is taken.
module device_table_wildcard_search_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] action, [7:2] previous_index, [16:8] class_code,
    // [25:17] subclass_code, [34:26] bus_number, [40:35] slot_number,
    // [44:41] function_number, [60:45] vendor_code, [76:61] device_code,
    // [79:77] zero
    input  logic [dtws_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] status, [6:2] entry_index, [14:7] match_class,
    // [22:15] match_subclass, [38:23] match_vendor, [54:39] match_device,
    // [62:55] match_bus, [67:63] match_slot, [70:68] match_function, [71] zero
    output logic [dtws_pkg::OUT_W-1:0]    m_tdata
);

    localparam int N = dtws_pkg::TABLE_ENTRIES;

    logic                         en;
    logic                         chain_valid [0:N];
    dtws_pkg::tok_t               chain_tok   [0:N];
    dtws_pkg::tok_t               last_tok;

    logic                         m_valid_reg;
    logic [dtws_pkg::OUT_W-1:0]   m_data_reg;
    logic [dtws_pkg::OUT_W-1:0]   m_data_next;
    logic [1:0]                   res_status;
    dtws_pkg::rec_t               res_rec;
    logic [4:0]                   res_idx;

    // Advance the chain unless a result is held by the receiver
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // Unpack the incoming transaction
    always_comb
    begin
        chain_valid[0]             = s_tvalid;
        chain_tok[0].action         = s_tdata[1:0];
        chain_tok[0].previous_index = s_tdata[7:2];
        chain_tok[0].cls_code       = s_tdata[16:8];
        chain_tok[0].subclass_code  = s_tdata[25:17];
        chain_tok[0].bus_number     = s_tdata[34:26];
        chain_tok[0].slot_number    = s_tdata[40:35];
        chain_tok[0].fn_number      = s_tdata[44:41];
        chain_tok[0].vendor_code    = s_tdata[60:45];
        chain_tok[0].device_code    = s_tdata[76:61];
        chain_tok[0].done           = 1'b0;
        chain_tok[0].res_idx        = '0;
        chain_tok[0].res_rec        = '0;
    end

    // Row of table cells
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        localparam logic [dtws_pkg::IDX_W-1:0] CELL_IDX = dtws_pkg::IDX_W'(g);

        dtws_cell u_cell
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (en),
            .cell_idx      (CELL_IDX),
            .tok_in_valid  (chain_valid[g]),
            .tok_in        (chain_tok[g]),
            .tok_out_valid (chain_valid[g+1]),
            .tok_out       (chain_tok[g+1])
        );
    end

    assign last_tok = chain_tok[N];

    // Form the result; an unclaimed operation reports full or no match
    always_comb
    begin
        if (last_tok.done)
        begin
            res_status = dtws_pkg::ST_OK;
            res_idx    = 5'(last_tok.res_idx);
            res_rec    = last_tok.res_rec;
        end
        else
        begin
            res_status = (last_tok.action == dtws_pkg::ACT_INSERT) ?
                         dtws_pkg::ST_FULL : dtws_pkg::ST_NONE;
            res_idx    = '0;
            res_rec    = '0;
        end
        m_data_next = {1'b0,
                       res_rec.fn_number,
                       res_rec.slot_number,
                       res_rec.bus_number,
                       res_rec.device_code,
                       res_rec.vendor_code,
                       res_rec.subclass_code,
                       res_rec.cls_code,
                       res_idx,
                       res_status};
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= chain_valid[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: rtl/dtws_checker.sv
`include "device_table_wildcard_search_unit_macros.svh"

module dtws_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [dtws_pkg::OUT_W-1:0]    m_tdata
);

    // Hold a stalled result
    `DTWS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Only the three defined status codes appear
    `DTWS_ASSERT_NOW(a_status_code, m_tvalid, (m_tdata[1:0] == dtws_pkg::ST_OK) || (m_tdata[1:0] == dtws_pkg::ST_NONE) || (m_tdata[1:0] == dtws_pkg::ST_FULL))

    // A failed operation carries a zero index and record
    `DTWS_ASSERT_NOW(a_fail_zero, m_tvalid && (m_tdata[1:0] != dtws_pkg::ST_OK), m_tdata[dtws_pkg::OUT_W-1:2] == '0)

    // Input backpressure only while a result is held
    `DTWS_ASSERT_NOW(a_ready_stall, !s_tready, m_tvalid && !m_tready)

endmodule

bind device_table_wildcard_search_unit dtws_checker u_dtws_checker (.*);
